[sv/mse_pkg.sv]
package mse_pkg;

    // Default list capacity
    localparam int MAX_KEYS = 1024;

    localparam int KEY_W = 32;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_DATA  = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    typedef struct packed {
        logic             command;
        logic [KEY_W-1:0] key_value;
        logic             final_key;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] sorted_value;
        logic             is_last;
        logic [1:0]       status;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD_WAIT,
        S_PASS_START,
        S_MERGE
    } t_state;

endpackage

[sv/mse_ram.sv]
module mse_ram #(
    parameter int  DEPTH = mse_pkg::MAX_KEYS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [mse_pkg::KEY_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr0,
    input  logic [AW-1:0]             i_raddr1,
    output logic [mse_pkg::KEY_W-1:0] o_rdata0,
    output logic [mse_pkg::KEY_W-1:0] o_rdata1
);

    logic [mse_pkg::KEY_W-1:0] r_mem [DEPTH];
    logic [mse_pkg::KEY_W-1:0] r_rdata0;
    logic [mse_pkg::KEY_W-1:0] r_rdata1;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata0 <= r_mem[i_raddr0];
        r_rdata1 <= r_mem[i_raddr1];
    end

    assign o_rdata0 = r_rdata0;
    assign o_rdata1 = r_rdata1;

endmodule

[sv/merge_sort_engine.sv]
// Stable ascending merge sort of up to MAX_KEYS unsigned 32-bit keys. A load transfer appends
// one key; the load flagged final_key starts the sort, during which the input is not ready.
// The sort runs ceil(log2 n) bottom-up merge passes over n keys; each pass primes the read
// ports in S_PASS_START, then writes one key per cycle by the single shared compare unit,
// ping-ponging between two key memories with no copy back. A read transfer waits on the
// registered memory read in S_RD_WAIT; a no-data read or an overflowing load answers
// directly. Results leave through an output register; the input is taken again as soon as
// that register is empty or being drained. Memory contents are not cleared at reset; only
// entries of the current list are ever used.
module merge_sort_engine #(
    parameter int MAX_KEYS = mse_pkg::MAX_KEYS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mse_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mse_pkg::t_out_item o_out_data
);

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);
    // bounds lo + 2*width stay below 3*MAX_KEYS
    localparam int PW = CW + 2;

    mse_pkg::t_state    r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_rdpos, n_rdpos;
    logic               r_done, n_done;
    logic               r_sel, n_sel;
    logic               r_out_valid, n_out_valid;
    mse_pkg::t_out_item r_out, n_out;
    logic [CW-1:0]      r_a, n_a;
    logic [CW-1:0]      r_b, n_b;
    logic [CW-1:0]      r_k, n_k;
    logic [CW-1:0]      r_mid, n_mid;
    logic [CW-1:0]      r_hi, n_hi;
    logic [PW-1:0]      r_width, n_width;

    logic                      we;
    logic                      wsel;
    logic [AW-1:0]             waddr;
    logic [mse_pkg::KEY_W-1:0] wdata;
    logic [AW-1:0]             raddr0;
    logic [AW-1:0]             raddr1;
    logic [mse_pkg::KEY_W-1:0] ram0_rd0, ram0_rd1, ram1_rd0, ram1_rd1;

    logic                      in_fire;
    logic [CW-1:0]             eff_count;
    logic                      has_room;
    logic [CW-1:0]             load_count;
    logic                      read_ok;
    logic [mse_pkg::KEY_W-1:0] src_a, src_b;
    logic                      take_a;
    logic [CW-1:0]             k_next;
    logic                      grp_done;
    logic                      pass_done;
    logic [PW-1:0]             width2;
    logic                      sort_end;
    logic [CW-1:0]             g_mid, g_hi, p_mid, p_hi;

    function automatic logic [CW-1:0] clip(input logic [PW-1:0] v, input logic [CW-1:0] n);
        logic [CW-1:0] res;
        res = (v > PW'(n)) ? n : v[CW-1:0];
        return res;
    endfunction

    mse_ram #(.DEPTH(MAX_KEYS)) u_ram0 (
        .i_clk    (i_clk),
        .i_we     (we && !wsel),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (ram0_rd0),
        .o_rdata1 (ram0_rd1)
    );

    mse_ram #(.DEPTH(MAX_KEYS)) u_ram1 (
        .i_clk    (i_clk),
        .i_we     (we && wsel),
        .i_waddr  (waddr),
        .i_wdata  (wdata),
        .i_raddr0 (raddr0),
        .i_raddr1 (raddr1),
        .o_rdata0 (ram1_rd0),
        .o_rdata1 (ram1_rd1)
    );

    // Input is taken only in idle, and only if a result would find the output register free
    assign o_in_ready  = (r_state == mse_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A load after a finished sort opens a new list
    assign eff_count  = r_done ? '0 : r_count;
    assign has_room   = eff_count < CW'(MAX_KEYS);
    assign load_count = eff_count + {{(CW-1){1'b0}}, has_room};
    assign read_ok    = r_done && (r_rdpos < r_count);

    // Port 0 carries the left run head (or the read-out key), port 1 the right run head
    assign src_a = r_sel ? ram1_rd0 : ram0_rd0;
    assign src_b = r_sel ? ram1_rd1 : ram0_rd1;

    // Shared compare unit: ties go left to keep the sort stable
    assign take_a    = (r_a < r_mid) && (!(r_b < r_hi) || (src_a <= src_b));
    assign k_next    = r_k + CW'(1);
    assign grp_done  = (k_next == r_hi);
    assign pass_done = grp_done && (r_hi == r_count);
    assign width2    = r_width << 1;
    assign sort_end  = width2 >= PW'(r_count);

    // Bounds of the next run pair within a pass, and of the first pair of a pass
    assign g_mid = clip(PW'(r_hi) + r_width, r_count);
    assign g_hi  = clip(PW'(r_hi) + width2, r_count);
    assign p_mid = clip(r_width, r_count);
    assign p_hi  = clip(width2, r_count);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mse_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.command == mse_pkg::CMD_READ) begin
                        if (read_ok) begin
                            n_state = mse_pkg::S_RD_WAIT;
                        end
                    end else if (i_in_data.final_key && (load_count > CW'(1))) begin
                        n_state = mse_pkg::S_PASS_START;
                    end
                end
            end
            mse_pkg::S_RD_WAIT: begin
                n_state = mse_pkg::S_IDLE;
            end
            mse_pkg::S_PASS_START: begin
                n_state = mse_pkg::S_MERGE;
            end
            mse_pkg::S_MERGE: begin
                if (pass_done) begin
                    n_state = sort_end ? mse_pkg::S_IDLE : mse_pkg::S_PASS_START;
                end
            end
            default: begin
                n_state = mse_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath, memory control and result register
    always_comb begin
        n_count     = r_count;
        n_rdpos     = r_rdpos;
        n_done      = r_done;
        n_sel       = r_sel;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_a         = r_a;
        n_b         = r_b;
        n_k         = r_k;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_width     = r_width;
        we          = 1'b0;
        wsel        = r_sel;
        waddr       = eff_count[AW-1:0];
        wdata       = i_in_data.key_value;
        raddr0      = r_rdpos[AW-1:0];
        raddr1      = r_b[AW-1:0];

        unique case (r_state)
            mse_pkg::S_IDLE: begin
                if (in_fire) begin
                    if (i_in_data.command == mse_pkg::CMD_LOAD) begin
                        n_count = load_count;
                        n_done  = 1'b0;
                        if (r_done) begin
                            n_rdpos = '0;
                        end
                        if (has_room) begin
                            we = 1'b1;
                        end else begin
                            n_out_valid        = 1'b1;
                            n_out.sorted_value = '0;
                            n_out.is_last      = 1'b0;
                            n_out.status       = mse_pkg::STATUS_OVERFLOW;
                        end
                        if (i_in_data.final_key) begin
                            n_rdpos = '0;
                            n_width = PW'(1);
                            // a single key is already sorted
                            if (load_count <= CW'(1)) begin
                                n_done = 1'b1;
                            end
                        end
                    end else if (!read_ok) begin
                        n_out_valid        = 1'b1;
                        n_out.sorted_value = '0;
                        n_out.is_last      = 1'b0;
                        n_out.status       = mse_pkg::STATUS_NO_DATA;
                    end
                end
            end
            mse_pkg::S_RD_WAIT: begin
                n_out_valid        = 1'b1;
                n_out.sorted_value = src_a;
                n_out.is_last      = ((r_rdpos + CW'(1)) == r_count);
                n_out.status       = mse_pkg::STATUS_OK;
                n_rdpos            = r_rdpos + CW'(1);
            end
            mse_pkg::S_PASS_START: begin
                // prime both read ports with the heads of the first run pair
                n_a    = '0;
                n_k    = '0;
                n_mid  = p_mid;
                n_b    = p_mid;
                n_hi   = p_hi;
                raddr0 = '0;
                raddr1 = p_mid[AW-1:0];
            end
            mse_pkg::S_MERGE: begin
                we    = 1'b1;
                wsel  = !r_sel;
                waddr = r_k[AW-1:0];
                wdata = take_a ? src_a : src_b;
                n_k   = k_next;
                n_a   = r_a + CW'(take_a);
                n_b   = r_b + CW'(!take_a);
                if (pass_done) begin
                    n_sel   = !r_sel;
                    n_width = width2;
                    if (sort_end) begin
                        n_done  = 1'b1;
                        n_rdpos = '0;
                    end
                end else if (grp_done) begin
                    n_a   = r_hi;
                    n_k   = r_hi;
                    n_mid = g_mid;
                    n_b   = g_mid;
                    n_hi  = g_hi;
                end
                raddr0 = n_a[AW-1:0];
                raddr1 = n_b[AW-1:0];
            end
            default: begin
                n_done = r_done;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mse_pkg::S_IDLE;
            r_count     <= '0;
            r_rdpos     <= '0;
            r_done      <= 1'b0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_rdpos     <= n_rdpos;
            r_done      <= n_done;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload and pointer registers hold no reset
    always_ff @(posedge i_clk) begin
        r_out   <= n_out;
        r_a     <= n_a;
        r_b     <= n_b;
        r_k     <= n_k;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_width <= n_width;
    end

endmodule

[dv/merge_sort_engine_test.sv]
`timescale 1ns / 1ps

module merge_sort_engine_test;

    localparam int KEY_W    = mse_pkg::KEY_W;
    localparam int MAX_KEYS = mse_pkg::MAX_KEYS;

    // Items in the directed and list-shaped random parts, before the capacity list
    localparam int unsigned RANDOM_ITEMS = 140;
    // Reads taken from the head of the full list
    localparam int unsigned CAP_READS = 32;
    // Item window in which neither side idles
    localparam int unsigned CALM_LO = 60;
    localparam int unsigned CALM_HI = 400;
    // Results to collect before the long output stall
    localparam int unsigned HOLD_AFTER = 30;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_CYCLES = 64;
    localparam int unsigned MAX_REPORTS = 10;

    typedef enum bit {ROW_PREDICT, ROW_FIXED} t_row_check;
    typedef enum bit [1:0] {MIX_WIDE, MIX_DUPS, MIX_SIGN, MIX_EXTREME} t_key_mix;

    typedef struct {
        mse_pkg::t_in_item  item;
        t_row_check         check;
        mse_pkg::t_out_item answer;
    } t_row;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    mse_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    mse_pkg::t_out_item out_data;

    // Shadow of the sorter: key list, read pointer and sorted flag
    logic [KEY_W-1:0] shadow_keys [MAX_KEYS];
    int unsigned      shadow_count;
    int unsigned      shadow_rd;
    bit               shadow_sorted;

    mse_pkg::t_out_item pending_results[$];
    t_row               rows[$];
    int unsigned        mismatches;
    int unsigned        results_seen;
    int unsigned        items_sent;
    bit                 calm;
    bit                 held;

    merge_sort_engine i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advance the shadow sorter by one accepted item; return 1 when the item answers.
    function automatic bit predict_sorter(input mse_pkg::t_in_item it,
                                          output mse_pkg::t_out_item res);
        bit               has_res;
        int               i;
        int               j;
        logic [KEY_W-1:0] v;
        res = '0;
        has_res = 1'b0;
        if (it.command == mse_pkg::CMD_LOAD) begin
            // A load after a finished sort opens a new list
            if (shadow_sorted) begin
                shadow_count = 0;
                shadow_rd = 0;
                shadow_sorted = 1'b0;
            end
            if (shadow_count < MAX_KEYS) begin
                shadow_keys[shadow_count] = it.key_value;
                shadow_count++;
            end else begin
                res.status = mse_pkg::STATUS_OVERFLOW;
                has_res = 1'b1;
            end
            if (it.final_key) begin
                // Stable insertion sort, unsigned compare
                for (i = 1; i < int'(shadow_count); i++) begin
                    v = shadow_keys[i];
                    j = i;
                    while (j > 0 && shadow_keys[j-1] > v) begin
                        shadow_keys[j] = shadow_keys[j-1];
                        j--;
                    end
                    shadow_keys[j] = v;
                end
                shadow_rd = 0;
                shadow_sorted = 1'b1;
            end
        end else if (!shadow_sorted || shadow_rd >= shadow_count) begin
            res.status = mse_pkg::STATUS_NO_DATA;
            has_res = 1'b1;
        end else begin
            res.sorted_value = shadow_keys[shadow_rd];
            res.is_last = (shadow_rd + 1 == shadow_count);
            res.status = mse_pkg::STATUS_OK;
            shadow_rd++;
            has_res = 1'b1;
        end
        return has_res;
    endfunction

    // Offer one item; enter and leave at a falling edge. Valid stays high across
    // back-to-back items, and drops only for random idle cycles.
    task automatic offer_item(input mse_pkg::t_in_item it, input t_row_check check = ROW_PREDICT,
                              input mse_pkg::t_out_item answer = '0);
        mse_pkg::t_out_item predicted;
        calm = (items_sent >= CALM_LO && items_sent < CALM_HI);
        while (!calm && $urandom_range(99) < 14) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        // Transfer taken at this edge
        if (predict_sorter(it, predicted))
            pending_results.push_back(check == ROW_FIXED ? answer : predicted);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic load_key(input logic [KEY_W-1:0] key, input logic fin);
        mse_pkg::t_in_item it;
        it.command   = mse_pkg::CMD_LOAD;
        it.key_value = key;
        it.final_key = fin;
        offer_item(it);
    endtask

    // Key and flag carry noise on a read; the block must ignore them
    task automatic read_key();
        mse_pkg::t_in_item it;
        it.command   = mse_pkg::CMD_READ;
        it.key_value = $urandom;
        it.final_key = 1'($urandom_range(1));
        offer_item(it);
    endtask

    function automatic void add_row(input logic command, input logic [KEY_W-1:0] key,
                                    input logic fin, input t_row_check check = ROW_PREDICT,
                                    input logic [KEY_W-1:0] value = '0,
                                    input logic last = 1'b0,
                                    input logic [1:0] status = mse_pkg::STATUS_OK);
        t_row r;
        r.item.command      = command;
        r.item.key_value    = key;
        r.item.final_key    = fin;
        r.check             = check;
        r.answer.sorted_value = value;
        r.answer.is_last      = last;
        r.answer.status       = status;
        rows.push_back(r);
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input t_key_mix mix);
        case (mix)
            MIX_DUPS:    return KEY_W'($urandom_range(7));
            MIX_SIGN:    return 32'h7FFF_FFFC + KEY_W'($urandom_range(7));
            MIX_EXTREME: return $urandom_range(1) ? 32'hFFFF_FFFF - KEY_W'($urandom_range(3))
                                                  : KEY_W'($urandom_range(3));
            default:     return $urandom;
        endcase
    endfunction

    // Output side: random stalls, one long hold once the block has had time to fill.
    initial begin
        out_ready = 1'b0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                out_ready <= calm || $urandom_range(99) >= 14;
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk) begin
        mse_pkg::t_out_item want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: value %h last %b status %0d",
                             out_data.sorted_value, out_data.is_last, out_data.status);
            end else begin
                want = pending_results.pop_front();
                if (out_data.sorted_value !== want.sorted_value ||
                    out_data.is_last !== want.is_last || out_data.status !== want.status) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result %0d: expected %h/%b/%0d, got %h/%b/%0d",
                                 results_seen, want.sorted_value, want.is_last, want.status,
                                 out_data.sorted_value, out_data.is_last, out_data.status);
                end
            end
        end
    end

    initial begin
        #10ms;
        $display("merge_sort_engine_test NOT OK");
        $finish;
    end

    initial begin
        int unsigned n_keys;
        int unsigned n_reads;
        t_key_mix    mix;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        calm     = 1'b0;
        mismatches   = 0;
        results_seen = 0;
        items_sent   = 0;
        shadow_count  = 0;
        shadow_rd     = 0;
        shadow_sorted = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty reads, sign-boundary ordering with a duplicate, read past
        // the end, single-key list, restart after a sort and abandoned reads.
        add_row(mse_pkg::CMD_READ, 32'h0, 1'b0, ROW_FIXED, 32'h0, 1'b0, mse_pkg::STATUS_NO_DATA);
        add_row(mse_pkg::CMD_LOAD, 32'hFFFF_FFFF, 1'b0);
        add_row(mse_pkg::CMD_LOAD, 32'h8000_0000, 1'b0);
        add_row(mse_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b1, ROW_FIXED, 32'h0, 1'b0,
                mse_pkg::STATUS_NO_DATA);
        add_row(mse_pkg::CMD_LOAD, 32'h7FFF_FFFF, 1'b0);
        add_row(mse_pkg::CMD_LOAD, 32'h0000_0000, 1'b0);
        add_row(mse_pkg::CMD_LOAD, 32'h8000_0000, 1'b0);
        add_row(mse_pkg::CMD_LOAD, 32'h0000_0001, 1'b1);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0, ROW_FIXED, 32'h0000_0000, 1'b0);
        add_row(mse_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b1, ROW_FIXED, 32'h0000_0001, 1'b0);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0, ROW_FIXED, 32'h7FFF_FFFF, 1'b0);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0, ROW_FIXED, 32'h8000_0000, 1'b0);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0, ROW_FIXED, 32'h8000_0000, 1'b0);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0, ROW_FIXED, 32'hFFFF_FFFF, 1'b1);
        add_row(mse_pkg::CMD_READ, 32'h0, 1'b0, ROW_FIXED, 32'h0, 1'b0, mse_pkg::STATUS_NO_DATA);
        add_row(mse_pkg::CMD_LOAD, 32'hA5A5_A5A5, 1'b1);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0, ROW_FIXED, 32'hA5A5_A5A5, 1'b1);
        add_row(mse_pkg::CMD_READ, 32'h0, 1'b0, ROW_FIXED, 32'h0, 1'b0, mse_pkg::STATUS_NO_DATA);
        add_row(mse_pkg::CMD_LOAD, 32'h5A5A_5A5A, 1'b0);
        add_row(mse_pkg::CMD_LOAD, 32'h0000_0003, 1'b0);
        add_row(mse_pkg::CMD_LOAD, 32'h0000_0002, 1'b1);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0);
        add_row(mse_pkg::CMD_LOAD, 32'hFFFF_FFFE, 1'b1);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0);
        add_row(mse_pkg::CMD_READ, 32'h0000_0000, 1'b0);
        foreach (rows[i]) offer_item(rows[i].item, rows[i].check, rows[i].answer);

        // Random lists: mostly short, now and then long; a stray read mid-list,
        // a dropped final flag, reads cut short or run past the end.
        while (items_sent < RANDOM_ITEMS) begin
            n_keys = ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            mix = t_key_mix'($urandom_range(3));
            for (int i = 0; i < int'(n_keys); i++) begin
                if ($urandom_range(19) == 0) read_key();
                load_key($urandom_range(3) == 0 ? pick_key(MIX_WIDE) : pick_key(mix),
                         i == int'(n_keys) - 1 && $urandom_range(15) != 0);
            end
            case ($urandom_range(7))
                0:       n_reads = $urandom_range(n_keys - 1);
                1:       n_reads = n_keys + $urandom_range(1, 3);
                default: n_reads = n_keys;
            endcase
            repeat (n_reads) read_key();
        end

        // Fill to capacity, overflow once plain and once carrying the final flag,
        // then read the head of the sorted list.
        for (int i = 0; i < MAX_KEYS; i++) load_key(pick_key(t_key_mix'($urandom_range(3))), 1'b0);
        load_key($urandom, 1'b0);
        load_key($urandom, 1'b1);
        repeat (CAP_READS) read_key();
        in_valid <= 1'b0;

        // Drain, then hold a while so a spurious late result is still caught
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("merge_sort_engine_test OK");
        end else begin
            $display("merge_sort_engine_test NOT OK");
        end
        $finish;
    end

endmodule
